// ===== sv/srrw_pkg.sv =====
package srrw_pkg;

  localparam int WINDOW_MAX    = 32;
  localparam int SEQ_BITS      = 16;
  localparam int WS_BITS       = 6;
  localparam int FPR_BITS      = 16;
  localparam int CNT_BITS      = 32;
  localparam int WIN_BITS      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_BITS      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NEXP_BITS     = SEQ_BITS + 1;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam int IN_DATA_BITS   = ((SEQ_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = SEQ_BITS + 1 + WIN_BITS + 1 + 1 + 2 * CNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE      = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAMES_PER_ROUND = CFG_IDX_BITS'(1);

  localparam logic [WS_BITS-1:0]  WS_RESET  = WS_BITS'(8);
  localparam logic [FPR_BITS-1:0] FPR_RESET = FPR_BITS'(16);

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic                bad;
    logic                good_end;
  } item_t;

  function automatic logic [WIN_BITS-1:0] eff_window(input logic [WS_BITS-1:0] ws);
    logic [WIN_BITS-1:0] w;
    if (ws == '0) begin
      w = WIN_BITS'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      w = WIN_BITS'(WINDOW_MAX);
    end else begin
      w = WIN_BITS'(ws);
    end
    return w;
  endfunction

  function automatic logic [WINDOW_MAX-1:0] win_mask(input logic [WIN_BITS-1:0] w);
    logic [WINDOW_MAX-1:0] m;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      m[i] = (WIN_BITS'(i) < w);
    end
    return m;
  endfunction

endpackage

// ===== sv/srrw_front.sv =====
module srrw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srrw_pkg::IN_DATA_BITS-1:0]   in_tdata,
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                q_valid,
  input  logic                                q_ready,
  output srrw_pkg::item_t                     q_item
);

  srrw_pkg::item_t slots_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  srrw_pkg::item_t item_in;

  // classify on entry
  always_comb begin
    item_in.seq      = in_tdata[srrw_pkg::SEQ_BITS-1:0];
    item_in.bad      = in_tuser;
    item_in.good_end = in_tlast & ~in_tuser;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slots_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;
  assign pop       = q_valid & q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== sv/srrw_back.sv =====
module srrw_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  srrw_pkg::item_t                      q_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srrw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [srrw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [srrw_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                 out_tuser
);

  localparam int NB = srrw_pkg::NEXP_BITS;
  localparam int WM = srrw_pkg::WINDOW_MAX;
  localparam int WB = srrw_pkg::WIN_BITS;
  localparam int CB = srrw_pkg::CNT_BITS;

  logic [srrw_pkg::WS_BITS-1:0]  ws_r, ws_nxt;
  logic [srrw_pkg::FPR_BITS-1:0] fpr_r, fpr_nxt;
  logic [NB-1:0]                 ne_r, ne_nxt;
  logic [WM-1:0]                 held_r, held_nxt;
  logic [NB-1:0]                 rl_r, rl_nxt;
  logic                          finishing_r, finishing_nxt;
  logic                          finished_r, finished_nxt;
  logic [CB-1:0]                 good_r, good_nxt;
  logic [CB-1:0]                 bad_r, bad_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [srrw_pkg::OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic                          out_neg_r, out_neg_nxt;

  logic                          fire, cfg_fire;
  logic [WB-1:0]                 w_eff;
  logic [WM-1:0]                 mask_w;
  logic [NB:0]                   win_top, seq_wide, ne_wide, diff;
  logic                          in_win, is_head, is_ahead;
  logic [WM-1:0]                 stop_vec;
  logic [WB-1:0]                 shift;
  logic [srrw_pkg::IDX_BITS-1:0] idx;
  logic                          store, rdone;
  logic [WB-1:0]                 adv;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign q_ready   = (~out_valid_r | out_tready) & ~cfg_valid;
  assign fire      = q_valid & q_ready;

  assign w_eff    = srrw_pkg::eff_window(ws_r);
  assign mask_w   = srrw_pkg::win_mask(w_eff);
  assign ne_wide  = {1'b0, ne_r};
  assign seq_wide = (NB + 1)'(q_item.seq);
  assign win_top  = ne_wide + (NB + 1)'(w_eff);
  assign in_win   = seq_wide < win_top;
  assign is_head  = seq_wide == ne_wide;
  assign is_ahead = seq_wide > ne_wide;
  assign diff     = seq_wide - ne_wide;
  assign idx      = diff[srrw_pkg::IDX_BITS-1:0];

  // run of held frames behind the head, bounded by the window
  assign stop_vec = ~held_r | ~mask_w;
  always_comb begin
    shift = WB'(WM);
    for (int i = WM - 1; i >= 1; i--) begin
      if (stop_vec[i]) begin
        shift = WB'(i);
      end
    end
  end

  always_comb begin
    ws_nxt        = ws_r;
    fpr_nxt       = fpr_r;
    ne_nxt        = ne_r;
    held_nxt      = held_r;
    rl_nxt        = rl_r;
    finishing_nxt = finishing_r;
    finished_nxt  = finished_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    store         = 1'b0;
    rdone         = 1'b0;
    adv           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_neg_nxt   = out_neg_r;

    if (cfg_fire) begin
      case (cfg_index)
        srrw_pkg::CFG_WINDOW_SIZE: begin
          ws_nxt   = cfg_data[srrw_pkg::WS_BITS-1:0];
          held_nxt = held_r & srrw_pkg::win_mask(
                       srrw_pkg::eff_window(cfg_data[srrw_pkg::WS_BITS-1:0]));
        end
        srrw_pkg::CFG_FRAMES_PER_ROUND: begin
          fpr_nxt = cfg_data[srrw_pkg::FPR_BITS-1:0];
          if (!finishing_r) begin
            rl_nxt = NB'(cfg_data[srrw_pkg::FPR_BITS-1:0]);
          end
        end
        default: begin
        end
      endcase
    end else if (fire) begin
      if (!finished_r) begin
        if (in_win) begin
          if (q_item.bad) begin
            bad_nxt = (bad_r == '1) ? bad_r : bad_r + CB'(1);
          end else begin
            good_nxt = (good_r == '1) ? good_r : good_r + CB'(1);
            if (is_head) begin
              store    = 1'b1;
              held_nxt = (held_r >> shift) & mask_w;
              ne_nxt   = ne_r + NB'(shift);
              adv      = shift;
            end else if (is_ahead) begin
              if (!held_r[idx]) begin
                held_nxt[idx] = 1'b1;
                store         = 1'b1;
              end
            end
            if (q_item.good_end) begin
              rl_nxt        = NB'(q_item.seq) + NB'(1);
              finishing_nxt = 1'b1;
            end
          end
        end
        if (ne_nxt >= rl_nxt) begin
          if (finishing_nxt) begin
            finished_nxt = 1'b1;
          end else begin
            rdone    = 1'b1;
            ne_nxt   = '0;
            held_nxt = '0;
            rl_nxt   = NB'(fpr_r);
          end
        end
      end
      out_valid_nxt = 1'b1;
      out_neg_nxt   = q_item.bad;
      out_data_nxt  = srrw_pkg::OUT_DATA_BITS'({bad_nxt, good_nxt, finished_nxt, rdone,
                                                 adv, store, q_item.seq});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= srrw_pkg::WS_RESET;
      fpr_r       <= srrw_pkg::FPR_RESET;
      ne_r        <= '0;
      held_r      <= '0;
      rl_r        <= NB'(srrw_pkg::FPR_RESET);
      finishing_r <= 1'b0;
      finished_r  <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ws_r        <= ws_nxt;
      fpr_r       <= fpr_nxt;
      ne_r        <= ne_nxt;
      held_r      <= held_nxt;
      rl_r        <= rl_nxt;
      finishing_r <= finishing_nxt;
      finished_r  <= finished_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_neg_r  <= out_neg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_neg_r;

endmodule

// ===== sv/selective_repeat_receive_window_core.sv =====
// Receive side of a selective-repeat window: every received frame yields one
// acknowledgement transaction carrying its sequence number, a store flag, the
// window advance, round and transfer status and saturating good/bad counts.
// One frame per clock is sustained while the output is accepted and no
// configuration write is pending. A frame taken in is held in the two-entry input
// queue, passes the window update (priority encode plus shift) in the back end and
// is presented from the registered output. A configuration write holds off the back
// end while cfg_valid is high and must only be issued with no frame in flight.
module selective_repeat_receive_window_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] seq_num
  input  logic [srrw_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [0] frame_bad
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] ack_seq, [16] store_payload, [22:17] advance, [23] round_done,
  // [24] transfer_done, [56:25] good_count, [88:57] bad_count
  output logic [srrw_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // [0] ack_negative
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srrw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [srrw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic            q_valid;
  logic            q_ready;
  srrw_pkg::item_t q_item;

  srrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  srrw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/sv/tb_selective_repeat_receive_window_core.sv =====
module tb_selective_repeat_receive_window_core;
  import srrw_pkg::*;

  localparam int ACK_LATENCY = 2;

  typedef struct packed {
    logic [SEQ_BITS-1:0] ack_seq;
    logic                ack_negative;
    logic                store_payload;
    logic [WIN_BITS-1:0] advance;
    logic                round_done;
    logic                transfer_done;
    logic [CNT_BITS-1:0] good_count;
    logic [CNT_BITS-1:0] bad_count;
  } ack_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [SEQ_BITS-1:0]      seq;
    logic                     bad;
    logic                     endf;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    bit                       known;
    ack_t                     ack;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     in_tlast = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // receive window state as the block should hold it
  logic [WS_BITS-1:0]    win_size_reg = WS_RESET;
  logic [FPR_BITS-1:0]   round_len_reg = FPR_RESET;
  logic [NEXP_BITS-1:0]  rx_next = '0;
  logic [WINDOW_MAX-1:0] rx_held = '0;
  logic [NEXP_BITS-1:0]  rx_limit = NEXP_BITS'(FPR_RESET);
  logic                  rx_armed = 1'b0;
  logic                  rx_finished = 1'b0;
  logic [CNT_BITS-1:0]   rx_good = '0;
  logic [CNT_BITS-1:0]   rx_bad = '0;

  ack_t pending_acks[$];
  int   mismatches = 0;
  int   frames_sent = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  int phase_ws [8] = '{8, 1, 32, 0, 63, 33, 17, 5};
  int phase_fpr [8] = '{16, 5, 40, 0, 7, 65535, 1, 12};

  selective_repeat_receive_window_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int window_span();
    if (win_size_reg == '0) begin
      return 1;
    end else if (int'(win_size_reg) > WINDOW_MAX) begin
      return WINDOW_MAX;
    end
    return int'(win_size_reg);
  endfunction

  function automatic logic [WINDOW_MAX-1:0] span_mask(int w);
    return WINDOW_MAX'((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic ack_t window_predict(logic [SEQ_BITS-1:0] seq, logic bad, logic endf);
    ack_t a;
    int   w;
    int   shift;
    int   offset;
    w = window_span();
    a = '0;
    a.ack_seq = seq;
    a.ack_negative = bad;
    if (!rx_finished) begin
      if (int'(seq) < int'(rx_next) + w) begin
        if (bad) begin
          rx_bad = bump(rx_bad);
        end else begin
          rx_good = bump(rx_good);
          if (int'(seq) == int'(rx_next)) begin
            shift = 1;
            while (shift < w && rx_held[shift]) shift++;
            rx_held = (rx_held >> shift) & span_mask(w);
            rx_next = rx_next + NEXP_BITS'(shift);
            a.store_payload = 1'b1;
            a.advance = WIN_BITS'(shift);
          end else if (int'(seq) > int'(rx_next)) begin
            offset = int'(seq) - int'(rx_next);
            if (!rx_held[offset]) begin
              rx_held[offset] = 1'b1;
              a.store_payload = 1'b1;
            end
          end
          if (endf) begin
            rx_limit = NEXP_BITS'(int'(seq) + 1);
            rx_armed = 1'b1;
          end
        end
      end
      if (rx_next >= rx_limit) begin
        if (rx_armed) begin
          rx_finished = 1'b1;
        end else begin
          a.round_done = 1'b1;
          rx_next = '0;
          rx_held = '0;
          rx_limit = NEXP_BITS'(round_len_reg);
        end
      end
    end
    a.transfer_done = rx_finished;
    a.good_count = rx_good;
    a.bad_count = rx_bad;
    return a;
  endfunction

  function automatic plan_row_t frame_row(logic [SEQ_BITS-1:0] seq, logic bad, logic endf);
    plan_row_t r;
    r.kind = ROW_FRAME;
    r.seq = seq;
    r.bad = bad;
    r.endf = endf;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.known = 1'b0;
    r.ack = '0;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [SEQ_BITS-1:0] seq, logic bad, logic endf,
                                          logic store, int adv, int goods, int bads);
    plan_row_t r;
    r = frame_row(seq, bad, endf);
    r.known = 1'b1;
    r.ack.ack_seq = seq;
    r.ack.ack_negative = bad;
    r.ack.store_payload = store;
    r.ack.advance = WIN_BITS'(adv);
    r.ack.good_count = CNT_BITS'(goods);
    r.ack.bad_count = CNT_BITS'(bads);
    return r;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] val);
    plan_row_t r;
    r = frame_row('0, 1'b0, 1'b0);
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_frame(input logic [SEQ_BITS-1:0] seq, input logic bad,
                            input logic endf, input bit known, input ack_t known_ack);
    int   gap;
    ack_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_BITS'(seq);
    in_tuser <= bad;
    in_tlast <= endf;
    do @(posedge clk); while (!in_tready);
    predicted = window_predict(seq, bad, endf);
    pending_acks.push_back(known ? known_ack : predicted);
    frames_sent++;
    if (frames_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  // wait for every outstanding ack before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (ACK_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) begin
      win_size_reg = val[WS_BITS-1:0];
      rx_held = rx_held & span_mask(window_span());
    end else begin
      round_len_reg = val[FPR_BITS-1:0];
      if (!rx_armed) rx_limit = NEXP_BITS'(round_len_reg);
    end
  endtask

  task automatic random_frames(input int n);
    int                  pick;
    int                  w;
    int                  base;
    logic [SEQ_BITS-1:0] seq;
    logic                bad;
    logic                endf;
    repeat (n) begin
      w = window_span();
      base = int'(rx_next);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        seq = SEQ_BITS'(base);
      end else if (pick < 65) begin
        seq = SEQ_BITS'(base + $urandom_range(1, w - 1));
      end else if (pick < 78 && base > 0) begin
        seq = SEQ_BITS'(base - $urandom_range(1, (base < 8) ? base : 8));
      end else if (pick < 88) begin
        seq = SEQ_BITS'(base + w + $urandom_range(0, 8));
      end else begin
        seq = SEQ_BITS'($urandom_range(0, 65535));
      end
      bad = ($urandom_range(0, 7) == 0);
      // an end flag on a good in-window frame would end the transfer for good
      endf = (bad || int'(seq) >= base + w) ? 1'($urandom_range(0, 1)) : 1'b0;
      send_frame(seq, bad, endf, 1'b0, '0);
    end
  endtask

  initial begin : ack_monitor
    int   stall;
    int   seen;
    ack_t got;
    ack_t want;
    seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      got.ack_seq = out_tdata[15:0];
      got.ack_negative = out_tuser;
      got.store_payload = out_tdata[16];
      got.advance = out_tdata[22:17];
      got.round_done = out_tdata[23];
      got.transfer_done = out_tdata[24];
      got.good_count = out_tdata[56:25];
      got.bad_count = out_tdata[88:57];
      if (pending_acks.size() == 0) begin
        $error("ack transaction with nothing pending, ack_seq %0d", got.ack_seq);
        mismatches++;
      end else begin
        want = pending_acks.pop_front();
        check_field("ack_seq", want.ack_seq, got.ack_seq);
        check_field("ack_negative", want.ack_negative, got.ack_negative);
        check_field("store_payload", want.store_payload, got.store_payload);
        check_field("advance", want.advance, got.advance);
        check_field("round_done", want.round_done, got.round_done);
        check_field("transfer_done", want.transfer_done, got.transfer_done);
        check_field("good_count", want.good_count, got.good_count);
        check_field("bad_count", want.bad_count, got.bad_count);
      end
      seen++;
      if (seen % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // right after reset: window 8, round of 16
    plan.push_back(known_row(16'd0, 1'b0, 1'b0, 1'b1, 1, 1, 0));
    plan.push_back(known_row(16'd3, 1'b0, 1'b0, 1'b1, 0, 2, 0));
    // duplicate of a held frame
    plan.push_back(known_row(16'd3, 1'b0, 1'b0, 1'b0, 0, 3, 0));
    // failed frame, end flag ignored
    plan.push_back(known_row(16'd2, 1'b1, 1'b1, 1'b0, 0, 3, 1));
    // beyond the window
    plan.push_back(known_row(16'hFFFF, 1'b0, 1'b1, 1'b0, 0, 3, 1));
    // below the window
    plan.push_back(known_row(16'd0, 1'b0, 1'b0, 1'b0, 0, 4, 1));
    plan.push_back(frame_row(16'd1, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd2, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd8, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd11, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd12, 1'b0, 1'b0));
    plan.push_back(frame_row(16'h5555, 1'b1, 1'b0));
    plan.push_back(frame_row(16'hAAAA, 1'b0, 1'b1));
    // zero window acts as one and drops held frames
    plan.push_back(write_row(CFG_WINDOW_SIZE, 16'd0));
    plan.push_back(frame_row(16'd5, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd4, 1'b0, 1'b0));
    plan.push_back(write_row(CFG_WINDOW_SIZE, 16'd63));
    // zero round length completes a round on every frame
    plan.push_back(write_row(CFG_FRAMES_PER_ROUND, 16'd0));
    plan.push_back(frame_row(16'd5, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd40, 1'b1, 1'b0));
    plan.push_back(write_row(CFG_FRAMES_PER_ROUND, 16'd3));
    plan.push_back(frame_row(16'd1, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd2, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd0, 1'b0, 1'b0));
    plan.push_back(write_row(CFG_FRAMES_PER_ROUND, 16'hFFFF));
    plan.push_back(frame_row(16'd31, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd0, 1'b0, 1'b0));
    plan.push_back(frame_row(16'd30, 1'b0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_frame(plan[i].seq, plan[i].bad, plan[i].endf, plan[i].known, plan[i].ack);
      end
    end

    foreach (phase_ws[p]) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_BITS'(phase_ws[p]));
        write_reg(CFG_FRAMES_PER_ROUND, CFG_DATA_BITS'(phase_fpr[p]));
      end else begin
        write_reg(CFG_FRAMES_PER_ROUND, CFG_DATA_BITS'(phase_fpr[p]));
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_BITS'(phase_ws[p]));
      end
      random_frames(150);
    end

    // closing transfer: arm ahead of the window, rewrite the round length while
    // armed, then finish with an end frame below the window
    write_reg(CFG_WINDOW_SIZE, 16'd1);
    write_reg(CFG_FRAMES_PER_ROUND, 16'd30);
    write_reg(CFG_WINDOW_SIZE, 16'd8);
    send_frame(rx_next[SEQ_BITS-1:0], 1'b0, 1'b0, 1'b0, '0);
    send_frame(rx_next[SEQ_BITS-1:0], 1'b0, 1'b0, 1'b0, '0);
    send_frame(SEQ_BITS'(rx_next + 3), 1'b0, 1'b1, 1'b0, '0);
    write_reg(CFG_FRAMES_PER_ROUND, 16'd50);
    send_frame(rx_next[SEQ_BITS-1:0], 1'b0, 1'b0, 1'b0, '0);
    send_frame(SEQ_BITS'(rx_next - 1), 1'b0, 1'b1, 1'b0, '0);
    random_frames(20);

    settle();
    if (mismatches == 0) begin
      $display("selective_repeat_receive_window_core verification clean");
    end else begin
      $display("selective_repeat_receive_window_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("selective_repeat_receive_window_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/srrw_pkg.sv
sv/srrw_front.sv
sv/srrw_back.sv
sv/selective_repeat_receive_window_core.sv
tb/sv/tb_selective_repeat_receive_window_core.sv
